/* rtl/signed_int_to_decimal_ascii_assert.svh */
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii assertion macros
// Shared concurrent assertion forms for the checker file.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// clocked check, disabled while reset is high
`define SIDA_ASSERT_SYNC(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define SIDA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sida_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_pkg
// Types, constants and the digit weight table shared by the converter.
// ---------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned NUM_POS = 10;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned TBL_W   = 34;
  localparam int unsigned CHAR_W  = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef logic [NUM_POS-1:0][NUM_POS-1:0][TBL_W-1:0] mult_tbl_t;

  // entry [k][d] holds d * 10**k
  function automatic mult_tbl_t build_mult_tbl();
    mult_tbl_t         tbl;
    logic [TBL_W-1:0]  p;
    p = TBL_W'(1);
    for (int k = 0; k < NUM_POS; k++) begin
      for (int d = 0; d < NUM_POS; d++) begin
        tbl[k][d] = TBL_W'(p * TBL_W'(d));
      end
      p = TBL_W'(p * TBL_W'(10));
    end
    return tbl;
  endfunction

  localparam mult_tbl_t MULT_TBL = build_mult_tbl();

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_zero;
  } dp_stat_t;

endpackage

/* rtl/sida_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_ctrl
// Sequencer: load, sign and digit count, then one digit per cycle.
// ---------------------------------------------------------------------------
module sida_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  sida_pkg::dp_stat_t stat,
  output sida_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import sida_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        cmd.step = 1'b1;
        if (stat.pos_zero) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sida_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_datapath
// Magnitude register, digit position and registered character output.
// ---------------------------------------------------------------------------
module sida_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [31:0]            value,
  input  sida_pkg::dp_cmd_t             cmd,
  output sida_pkg::dp_stat_t            stat,
  output logic                          strobe,
  output logic [sida_pkg::CHAR_W-1:0]   char_code,
  output logic                          is_last
);
  import sida_pkg::*;

  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] mag_next;
  logic             neg;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_count;
  logic [POS_W-1:0] digit;
  logic [TBL_W-1:0] sub;

  // number of digits minus one
  always_comb begin
    pos_count = '0;
    for (int k = 1; k < NUM_POS; k++) begin
      pos_count = pos_count + POS_W'(mag >= MULT_TBL[k][1][MAG_W-1:0]);
    end
  end

  // largest d with d * 10**pos not above the remainder
  always_comb begin
    digit = '0;
    for (int d = 1; d < NUM_POS; d++) begin
      digit = digit + POS_W'({2'b00, mag} >= MULT_TBL[pos][d]);
    end
    sub      = MULT_TBL[pos][digit];
    mag_next = mag - sub[MAG_W-1:0];
  end

  assign stat.pos_zero = (pos == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= value[31] ? (~$unsigned(value) + 32'd1) : $unsigned(value);
      neg <= value[31];
    end else if (cmd.step) begin
      mag <= mag_next;
    end
    if (cmd.prep) begin
      pos <= pos_count;
    end else if (cmd.step) begin
      pos <= pos - POS_W'(1);
    end
    if (cmd.prep) begin
      char_code <= CHAR_MINUS;
      is_last   <= 1'b0;
    end else if (cmd.step) begin
      char_code <= CHAR_ZERO + CHAR_W'(digit);
      is_last   <= (pos == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.prep & neg) | cmd.step;
    end
  end

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per cycle.
// ---------------------------------------------------------------------------
// usage:
//   a word is taken at a rising edge with start high and busy low.
//   characters come out most significant first on char_code, one per
//   cycle with strobe high for exactly that cycle; is_last marks the
//   final character. a negative value gives a leading minus sign.
// sequence:
//   the minus sign, when present, appears after the prep state that follows
//   the accepting edge, and the first digit after the first digit state;
//   the rest follow gapless. busy stays high through the prep state and
//   every digit state; no new word is taken until busy is low again. the digit
//   loop resolves one decimal digit per cycle with parallel compares
//   against the digit weight table, then one subtract.
// reset:
//   synchronous, active high; returns the sequencer to idle and drops
//   strobe. no state is kept between words.
// output side:
//   the receiver cannot stall; each character is shown for one cycle.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [31:0]          value,
  output logic                        busy,
  output logic                        strobe,
  output logic [sida_pkg::CHAR_W-1:0] char_code,
  output logic                        is_last
);
  import sida_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sida_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sida_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .strobe    (strobe),
    .char_code (char_code),
    .is_last   (is_last)
  );

endmodule

/* rtl/sida_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_checker
// Port-level checks on the character stream of the converter.
// ---------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        strobe,
  input logic [sida_pkg::CHAR_W-1:0] char_code,
  input logic                        is_last
);
  import sida_pkg::*;

  logic accept;
  assign accept = start & ~busy;

  `SIDA_ASSERT_SYNC(a_char_range, clk, rst, strobe |-> (char_code == CHAR_MINUS || (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 6'd9)), "character out of range")
  `SIDA_ASSERT_SYNC(a_accept_busy, clk, rst, accept |=> busy, "busy not raised after accept")
  `SIDA_ASSERT_SYNC(a_word_gapless, clk, rst, (strobe && !is_last) |=> strobe, "gap inside a word")
  `SIDA_ASSERT_ALWAYS(a_last_ends, clk, (strobe && is_last && !rst) |=> !strobe, "strobe after last character")

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the signed integer to decimal ASCII converter.
// A table of directed words (zero, sign boundaries, digit-count edges) is
// followed by random words in four idle phases. Every character on the
// strobe is compared, code and last flag, with a queue of expected
// characters filled at each accepted word.
// ---------------------------------------------------------------------------
module tb;

  localparam int DIR_N     = 22;
  localparam int RAND_N    = 64;
  localparam int LIMIT     = 200000;
  localparam int MAX_SHOWN = 10;

  logic                          clk   = 1'b0;
  logic                          rst   = 1'b1;
  logic                          start = 1'b0;
  logic signed [31:0]            value = '0;
  logic                          busy;
  logic                          strobe;
  logic [sida_pkg::CHAR_W-1:0]   char_code;
  logic                          is_last;

  logic [sida_pkg::CHAR_W-1:0]   char_q [$];
  logic                          last_q [$];
  logic [sida_pkg::CHAR_W-1:0]   want_char;
  logic                          want_last;
  int                            errors = 0;
  int                            cycles = 0;
  int                            idle_pct = 0;

  // typed text only where it is obvious; empty rows use the predictor
  logic signed [31:0] dir_val [DIR_N] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd2147483647, 32'h8000_0000,
    -32'sd2147483647, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    -32'sd7, 32'sd12345, 32'sd999999999, 32'sd1000000000, -32'sd999999999,
    -32'sd1000000000, 32'sd1000000001, 32'h5555_5555, 32'hAAAA_AAAA,
    32'sd2000000000, -32'sd2000000000
  };
  string dir_text [DIR_N] = '{
    "0", "1", "-1", "2147483647", "-2147483648",
    "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .strobe    (strobe),
    .char_code (char_code),
    .is_last   (is_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // digits from a 32-bit magnitude, so the most negative value is exact
  function automatic string decimal_text(input logic signed [31:0] v);
    logic [31:0] mag;
    string       s;
    s   = "";
    mag = v;
    if (v[31]) mag = 32'd0 - mag;
    do begin
      s   = $sformatf("%0d%s", mag % 32'd10, s);
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (v[31]) s = {"-", s};
    return s;
  endfunction

  function automatic void push_text(input string s);
    byte b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      char_q.push_back(b[sida_pkg::CHAR_W-1:0]);
      last_q.push_back(i == s.len() - 1);
    end
  endfunction

  task automatic send_word(input logic signed [31:0] v, input string text);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    push_text((text.len() != 0) ? text : decimal_text(v));
  endtask

  function automatic logic signed [31:0] random_word();
    longint p;
    longint m;
    int     nd;
    nd = $urandom_range(1, 10);
    p  = 1;
    repeat (nd) p = p * 10;
    case ($urandom_range(0, 2))
      0: m = longint'($urandom);
      1: m = longint'($urandom) % p;
      default: m = p + $urandom_range(0, 2) - 1;
    endcase
    if ($urandom_range(0, 1)) m = -m;
    return m[31:0];
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (char_q.size() == 0) begin
        note_error($sformatf("unexpected char: code %0d last %0b", char_code, is_last));
      end else begin
        want_char = char_q.pop_front();
        want_last = last_q.pop_front();
        if (char_code !== want_char || is_last !== want_last) begin
          note_error($sformatf("char mismatch: expected code %0d last %0b, got code %0d last %0b",
                               want_char, want_last, char_code, is_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 30;
    for (int i = 0; i < DIR_N; i++) send_word(dir_val[i], dir_text[i]);

    // no idle, sender idle 62, no idle again, sender idle 18
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 62;
        2: idle_pct = 0;
        default: idle_pct = 18;
      endcase
      for (int i = 0; i < RAND_N; i++) send_word(random_word(), "");
    end
    start <= 1'b0;

    while (char_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sida_pkg.sv
rtl/sida_ctrl.sv
rtl/sida_datapath.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/sida_checker.sv
bench/tb.sv
